FILE: rtl/first_fit_segment_allocator_top_macros.svh
// Assertion macros shared by the first-fit segment allocator RTL.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FFSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ffsa assertion failed");
`define FFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsa assertion failed");
`else
`define FFSA_ASSERT(lbl, clk, rst_n, prop)
`define FFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ffsa_pkg.sv
// Types, constants and codes of the first-fit segment allocator.
package ffsa_pkg;

    localparam int unsigned DEF_MAX_SEGMENTS    = 64;
    localparam int unsigned DEF_HEADER_BYTES    = 20;
    localparam int unsigned DEF_MIN_SPLIT_SLACK = 16;

    localparam logic [31:0] RESET_BASE  = 32'h0010_0000;
    localparam logic [31:0] RESET_BYTES = 32'h0040_0000;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_ZERO     = 2'd1;
    localparam logic [1:0] STS_NOFIT    = 2'd2;
    localparam logic [1:0] STS_BAD_FREE = 2'd3;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 1'b1;

    typedef struct packed {
        logic        live;
        logic        fr;
        logic [31:0] off;
        logic [31:0] pay;
    } t_seg;

    localparam t_seg SEG_DEAD = '0;

    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [31:0] off;
        logic [31:0] pay;
    } t_tok;

    typedef struct packed {
        logic valid;
        t_seg seg;
    } t_ins;

    typedef struct packed {
        logic valid;
        logic two;
    } t_del;

    typedef struct packed {
        logic        is_free;
        logic [32:0] size;
        logic [31:0] tgt;
    } t_op;

    typedef struct packed {
        logic        cmd;
        logic [31:0] request_size;
        logic [31:0] payload_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_address;
        logic [31:0] used_total;
        logic [31:0] free_total;
    } t_out_item;

endpackage

FILE: rtl/first_fit_segment_allocator_top.sv
// Top level of the first-fit segment allocator with its sequencer and totals.
//
//  Channel  Direction  Handshake                    Payload
//  in       input      i_in_valid / o_in_stall      i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_stall    o_out_data (t_out_item)
//  cfg      input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// For an allocate or free, a scan token walks the cell row one segment per cycle, and a split
// shift travels alongside it.
// A merge into the left neighbour trails the token by one cell.
// A zero-size allocate goes straight to its result without a scan. One transaction is in work at a time.
// Reset and a heap size write rebuild the single free segment.
// A result held by a stalled output does not block the acceptance of the next input.
module first_fit_segment_allocator_top #(
    parameter int unsigned MAX_SEGMENTS    = ffsa_pkg::DEF_MAX_SEGMENTS,
    parameter int unsigned HEADER_BYTES    = ffsa_pkg::DEF_HEADER_BYTES,
    parameter int unsigned MIN_SPLIT_SLACK = ffsa_pkg::DEF_MIN_SPLIT_SLACK
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ffsa_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ffsa_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                      i_cfg_data
);
    `include "first_fit_segment_allocator_top_macros.svh"
    import ffsa_pkg::*;

    localparam logic [31:0] HDR = 32'(HEADER_BYTES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state      r_state;
    logic [31:0] r_base, r_bytes, r_used;
    logic        r_cmd, r_zero, r_hit;
    logic [32:0] r_size;
    logic [31:0] r_tgt, r_goff, r_gpay;
    logic        r_ovld;
    t_out_item   r_out;

    logic        w_in_acc, w_load, w_init, w_busy;
    logic [31:0] w_total, w_used_nx, w_init_src, w_init_pay;
    logic [1:0]  w_status;
    t_op         w_op;
    t_tok        w_tok_in, w_tok_out;

    assign w_in_acc   = i_in_valid & (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_init     = i_cfg_we & (i_cfg_idx == CFG_HEAP_BYTES);
    assign w_init_src = i_rst_n ? i_cfg_data : RESET_BYTES;
    assign w_init_pay = (w_init_src >= HDR) ? w_init_src - HDR : 32'd0;
    assign w_total    = (r_bytes >= HDR) ? r_bytes : HDR;
    assign w_load     = (r_state == S_DONE) & (!r_ovld | !i_out_stall);

    assign w_op = '{is_free: r_cmd, size: r_size, tgt: r_tgt};

    always_comb begin
        w_tok_in       = '0;
        w_tok_in.valid = w_in_acc
                       & !((i_in_data.cmd == CMD_ALLOC) & (i_in_data.request_size == 32'd0));
    end

    ffsa_chain #(
        .MAX_SEGMENTS   (MAX_SEGMENTS),
        .HEADER_BYTES   (HEADER_BYTES),
        .MIN_SPLIT_SLACK(MIN_SPLIT_SLACK)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_init    (w_init),
        .i_init_pay(w_init_pay),
        .i_tok     (w_tok_in),
        .o_tok     (w_tok_out),
        .o_busy    (w_busy)
    );

    always_comb begin
        w_used_nx = r_used;
        if (r_hit) begin
            if (r_cmd == CMD_ALLOC) begin
                w_used_nx = r_used + r_gpay + HDR;
            end else begin
                w_used_nx = r_used - r_gpay - HDR;
            end
        end
        if (r_zero) begin
            w_status = STS_ZERO;
        end else if (r_hit) begin
            w_status = STS_OK;
        end else if (r_cmd == CMD_ALLOC) begin
            w_status = STS_NOFIT;
        end else begin
            w_status = STS_BAD_FREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= RESET_BASE;
            r_bytes <= RESET_BYTES;
            r_used  <= '0;
            r_ovld  <= 1'b0;
            r_hit   <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && !w_load) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd  <= i_in_data.cmd;
                        r_size <= ({1'b0, i_in_data.request_size} + 33'd7) & ~33'd7;
                        r_tgt  <= i_in_data.payload_address - r_base - HDR;
                        r_hit  <= 1'b0;
                        r_zero <= !w_tok_in.valid;
                        r_state <= w_tok_in.valid ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    if (w_tok_out.valid) begin
                        r_hit   <= w_tok_out.hit;
                        r_goff  <= w_tok_out.off;
                        r_gpay  <= w_tok_out.pay;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!w_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_ovld  <= 1'b1;
                        r_used  <= w_used_nx;
                        r_out.status          <= w_status;
                        r_out.granted_address <= (r_hit && r_cmd == CMD_ALLOC)
                                               ? r_base + r_goff + HDR : 32'd0;
                        r_out.used_total      <= w_used_nx;
                        r_out.free_total      <= w_total - w_used_nx;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEAP_BASE: begin
                        r_base <= i_cfg_data;
                    end
                    CFG_HEAP_BYTES: begin
                        r_bytes <= i_cfg_data;
                        r_used  <= '0;
                    end
                    default: begin
                        r_base <= r_base;
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    `FFSA_ASSERT(a_used_within_heap, i_clk, i_rst_n, r_used <= w_total)
    `FFSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, o_in_stall)

endmodule

FILE: rtl/ffsa_cell.sv
// One segment cell of the allocator chain with its travelling tokens.
module ffsa_cell #(
    parameter int unsigned HEADER_BYTES    = ffsa_pkg::DEF_HEADER_BYTES,
    parameter int unsigned MIN_SPLIT_SLACK = ffsa_pkg::DEF_MIN_SPLIT_SLACK
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ffsa_pkg::t_op  i_op,
    input  logic           i_init,
    input  ffsa_pkg::t_seg i_init_seg,
    input  logic           i_full,
    input  logic           i_right_hit,
    input  ffsa_pkg::t_seg i_prev,
    input  ffsa_pkg::t_seg i_next,
    input  ffsa_pkg::t_seg i_next2,
    input  ffsa_pkg::t_tok i_tok,
    input  ffsa_pkg::t_ins i_ins,
    input  ffsa_pkg::t_del i_del,
    output ffsa_pkg::t_seg o_seg,
    output ffsa_pkg::t_tok o_tok,
    output ffsa_pkg::t_ins o_ins,
    output ffsa_pkg::t_del o_del,
    output logic           o_hit,
    output logic           o_busy
);
    import ffsa_pkg::*;

    localparam logic [31:0] HDR       = 32'(HEADER_BYTES);
    localparam logic [31:0] SPLIT_MIN = 32'(HEADER_BYTES + MIN_SPLIT_SLACK);

    t_seg r_seg, n_seg;
    t_tok r_tok;
    t_ins r_ins;
    t_del r_del, n_del;

    logic        w_match, w_hit, w_split, w_absorb;
    logic        w_left_free, w_right_free, w_right2_free;
    logic [31:0] w_rest;
    t_seg        w_new_seg;

    always_comb begin
        w_left_free   = i_prev.live & i_prev.fr;
        w_right_free  = i_next.live & i_next.fr;
        w_right2_free = i_next2.live & i_next2.fr;
        if (i_op.is_free) begin
            w_match = r_seg.live & !r_seg.fr & (r_seg.off == i_op.tgt);
        end else begin
            w_match = r_seg.live & r_seg.fr & ({1'b0, r_seg.pay} >= i_op.size);
        end
        w_hit     = r_tok.valid & !r_tok.hit & w_match;
        w_rest    = r_seg.pay - i_op.size[31:0];
        w_split   = !i_op.is_free & (w_rest > SPLIT_MIN) & !i_full;
        w_absorb  = i_right_hit & i_op.is_free & r_seg.live & r_seg.fr;
        w_new_seg = '{live: 1'b1, fr: 1'b1, off: r_seg.off + HDR + i_op.size[31:0],
                      pay: w_rest - HDR};
    end

    always_comb begin
        n_seg = r_seg;
        if (r_del.valid) begin
            n_seg = r_del.two ? i_next2 : i_next;
        end else if (r_ins.valid) begin
            n_seg = r_ins.seg;
        end else if (w_hit) begin
            if (!i_op.is_free) begin
                n_seg.fr = 1'b0;
                if (w_split) begin
                    n_seg.pay = i_op.size[31:0];
                end
            end else if (!w_left_free) begin
                n_seg.fr = 1'b1;
                if (w_right_free) begin
                    n_seg.pay = r_seg.pay + HDR + i_next.pay;
                end
            end
        end else if (w_absorb) begin
            n_seg.pay = r_seg.pay + HDR + i_next.pay
                      + (w_right2_free ? HDR + i_next2.pay : 32'd0);
        end
    end

    always_comb begin
        o_tok = r_tok;
        if (w_hit) begin
            o_tok.hit = 1'b1;
            o_tok.off = r_seg.off;
            o_tok.pay = w_split ? i_op.size[31:0] : r_seg.pay;
        end
        if (r_ins.valid) begin
            o_ins = '{valid: 1'b1, seg: r_seg};
        end else if (w_hit & w_split) begin
            o_ins = '{valid: 1'b1, seg: w_new_seg};
        end else begin
            o_ins = '0;
        end
        if (r_del.valid) begin
            o_del = r_del;
        end else begin
            o_del = '{valid: w_hit & i_op.is_free & !w_left_free & w_right_free, two: 1'b0};
        end
        if (i_del.valid) begin
            n_del = i_del;
        end else begin
            n_del = '{valid: w_hit & i_op.is_free & w_left_free, two: w_right_free};
        end
    end

    assign o_seg  = r_seg;
    assign o_hit  = w_hit;
    assign o_busy = r_ins.valid | r_del.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_seg <= i_init_seg;
            r_tok <= '0;
            r_ins <= '0;
            r_del <= '0;
        end else begin
            r_seg <= n_seg;
            r_tok <= i_tok;
            r_ins <= i_ins;
            r_del <= n_del;
        end
    end

endmodule

FILE: rtl/ffsa_chain.sv
// Row of segment cells that holds the address-ordered segment table.
module ffsa_chain #(
    parameter int unsigned MAX_SEGMENTS    = ffsa_pkg::DEF_MAX_SEGMENTS,
    parameter int unsigned HEADER_BYTES    = ffsa_pkg::DEF_HEADER_BYTES,
    parameter int unsigned MIN_SPLIT_SLACK = ffsa_pkg::DEF_MIN_SPLIT_SLACK
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ffsa_pkg::t_op  i_op,
    input  logic           i_init,
    input  logic [31:0]    i_init_pay,
    input  ffsa_pkg::t_tok i_tok,
    output ffsa_pkg::t_tok o_tok,
    output logic           o_busy
);
    `include "first_fit_segment_allocator_top_macros.svh"
    import ffsa_pkg::*;

    t_seg w_seg [0:MAX_SEGMENTS+1];
    t_tok w_tok [0:MAX_SEGMENTS];
    t_ins w_ins [0:MAX_SEGMENTS];
    t_del w_del [0:MAX_SEGMENTS];
    logic [MAX_SEGMENTS:0]   w_hit;
    logic [MAX_SEGMENTS:0]   w_busy_v;
    logic [MAX_SEGMENTS-1:0] w_tok_v;
    logic                    w_full;

    assign w_seg[MAX_SEGMENTS]   = SEG_DEAD;
    assign w_seg[MAX_SEGMENTS+1] = SEG_DEAD;
    assign w_tok[0]              = i_tok;
    assign w_ins[0]              = '0;
    assign w_del[0]              = '0;
    assign w_hit[MAX_SEGMENTS]   = 1'b0;
    assign w_full                = w_seg[MAX_SEGMENTS-1].live;

    for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
        t_seg w_prev, w_init_seg;
        if (k == 0) begin : g_head
            assign w_prev     = SEG_DEAD;
            assign w_init_seg = '{live: 1'b1, fr: 1'b1, off: 32'd0, pay: i_init_pay};
        end else begin : g_body
            assign w_prev     = w_seg[k-1];
            assign w_init_seg = SEG_DEAD;
        end
        ffsa_cell #(
            .HEADER_BYTES   (HEADER_BYTES),
            .MIN_SPLIT_SLACK(MIN_SPLIT_SLACK)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (i_op),
            .i_init     (i_init),
            .i_init_seg (w_init_seg),
            .i_full     (w_full),
            .i_right_hit(w_hit[k+1]),
            .i_prev     (w_prev),
            .i_next     (w_seg[k+1]),
            .i_next2    (w_seg[k+2]),
            .i_tok      (w_tok[k]),
            .i_ins      (w_ins[k]),
            .i_del      (w_del[k]),
            .o_seg      (w_seg[k]),
            .o_tok      (w_tok[k+1]),
            .o_ins      (w_ins[k+1]),
            .o_del      (w_del[k+1]),
            .o_hit      (w_hit[k]),
            .o_busy     (w_busy_v[k])
        );
        assign w_tok_v[k] = w_tok[k+1].valid;
    end

    assign w_busy_v[MAX_SEGMENTS] = w_ins[MAX_SEGMENTS].valid | w_del[MAX_SEGMENTS].valid;
    assign o_busy = |w_busy_v;
    assign o_tok  = w_tok[MAX_SEGMENTS];

    `FFSA_ASSERT(a_single_scan_token, i_clk, i_rst_n, $onehot0(w_tok_v))
    `FFSA_ASSERT(a_single_hit, i_clk, i_rst_n, $onehot0(w_hit))

endmodule
